// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle implication failed");

`endif

// ===== hdl/mvn_pkg.sv =====
package mvn_pkg;
   localparam int MAX_BASIS   = 64;
   localparam int IDX_W       = 6;
   localparam int LEN_W       = 7;
   localparam int OV_AW       = 2 * IDX_W;
   localparam int DATA_W      = 32;
   localparam int ACC_W       = 128;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic FUNC_OVERLAP = 1'b0;
   localparam logic FUNC_PUSH    = 1'b1;

   typedef struct packed {
      logic              ov_we;
      logic [OV_AW-1:0]  ov_addr;
      logic              vec_we;
      logic [IDX_W-1:0]  vec_addr;
      logic [DATA_W-1:0] data;
      logic [IDX_W-1:0]  basis;
   } wr_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             bad;
   } run_type;

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction
endpackage

// ===== hdl/mvn_front.sv =====
module mvn_front import mvn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_func,
   input  logic [IDX_W-1:0]  req_row_index,
   input  logic [IDX_W-1:0]  req_col_index,
   input  logic [DATA_W-1:0] req_value,
   input  logic              req_last,
   output wr_type            wr,
   output logic              push,
   output run_type           run
);
   logic [LEN_W-1:0] len_ff, len_in;
   logic             bad_ff, bad_in;
   logic             accept, room, row_ok, col_ok;

   always_comb begin
      accept = start && !busy;
      room   = len_ff < LEN_W'(MAX_BASIS);
      row_ok = {1'b0, req_row_index} < LEN_W'(MAX_BASIS);
      col_ok = {1'b0, req_col_index} < LEN_W'(MAX_BASIS);
      wr.ov_we    = accept && (req_func == FUNC_OVERLAP) && row_ok && col_ok;
      wr.ov_addr  = {req_row_index, req_col_index};
      wr.vec_we   = accept && (req_func == FUNC_PUSH) && room;
      wr.vec_addr = len_ff[IDX_W-1:0];
      wr.data     = req_value;
      wr.basis    = req_row_index;
      len_in = len_ff;
      bad_in = bad_ff;
      if (wr.vec_we) begin
         len_in = len_ff + 1'b1;
         if (!row_ok) bad_in = 1'b1;
      end
      push    = accept && (req_func == FUNC_PUSH) && req_last;
      run.len = len_in;
      run.bad = bad_in;
      if (push) begin
         len_in = '0;
         bad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         bad_ff <= bad_in;
      end
   end
endmodule

// ===== hdl/mvn_queue.sv =====
module mvn_queue import mvn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type din,
   input  logic    pop,
   output run_type dout,
   output logic    empty
);
   run_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, rp_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule

// ===== hdl/mvn_back.sv =====
module mvn_back import mvn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  wr_type            wr,
   input  logic              empty,
   input  run_type           run,
   output logic              pop,
   output logic              active,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_scaled_value,
   output logic [IDX_W-1:0]  rsp_position,
   output logic              rsp_error,
   output logic              rsp_end_of_run
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_T0   = 4'd1;
   localparam logic [3:0] ST_T1   = 4'd2;
   localparam logic [3:0] ST_T2   = 4'd3;
   localparam logic [3:0] ST_T3   = 4'd4;
   localparam logic [3:0] ST_T4   = 4'd5;
   localparam logic [3:0] ST_CHK  = 4'd6;
   localparam logic [3:0] ST_NORM = 4'd7;
   localparam logic [3:0] ST_SQRT = 4'd8;
   localparam logic [3:0] ST_SCR  = 4'd9;
   localparam logic [3:0] ST_SCL  = 4'd10;
   localparam logic [3:0] ST_SCD  = 4'd11;
   localparam logic [3:0] ST_SCO  = 4'd12;
   localparam logic [3:0] ST_ERR  = 4'd13;
   localparam int VW = IDX_W + DATA_W;

   logic [VW-1:0]     vec_mem [MAX_BASIS];
   logic [DATA_W-1:0] ov_mem [MAX_BASIS*MAX_BASIS];
   logic [VW-1:0]     rda_ff, rdb_ff;
   logic [DATA_W-1:0] ovr_ff;

   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] n_ff, n_in, cnt_ff, cnt_in, k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [ACC_W-1:0] acc_ff, acc_in, nn_ff, nn_in, num_ff, num_in;
   logic [63:0]      prod_ff, prod_in, plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0]      root_ff, root_in, dr_ff, dr_in;
   logic [65:0]      rem_ff, rem_in;
   logic [32:0]      q_ff, q_in;
   logic             sign_ff, sign_in, sticky_ff, sticky_in, sat_ff, sat_in;
   logic             neg_ff, neg_in;
   logic             vld_ff, vld_in, err_ff, err_in, end_ff, end_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;

   logic [ACC_W-1:0]  term;
   logic [65:0]       rt, trial;
   logic [63:0]       dt;
   logic [7:0]        shamt;
   logic [159:0]      sh;
   logic [32:0]       limit;
   logic [DATA_W-1:0] ma;
   logic              over;

   always_ff @(posedge clock) begin
      if (wr.vec_we) vec_mem[wr.vec_addr] <= {wr.basis, wr.data};
      rda_ff <= vec_mem[i_ff];
      rdb_ff <= vec_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (wr.ov_we) ov_mem[wr.ov_addr] <= wr.data;
      ovr_ff <= ov_mem[{rda_ff[VW-1:DATA_W], rdb_ff[VW-1:DATA_W]}];
   end

   assign pop    = (state_ff == ST_IDLE) && !empty;
   assign active = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;  n_in = n_ff;  cnt_in = cnt_ff;  k_in = k_ff;
      i_in = i_ff;  j_in = j_ff;  acc_in = acc_ff;  nn_in = nn_ff;
      num_in = num_ff;  prod_in = prod_ff;  plo_in = plo_ff;  phi_in = phi_ff;
      root_in = root_ff;  dr_in = dr_ff;  rem_in = rem_ff;  q_in = q_ff;
      sign_in = sign_ff;  sticky_in = sticky_ff;  sat_in = sat_ff;  neg_in = neg_ff;
      vld_in = 1'b0;  err_in = err_ff;  end_in = end_ff;
      val_in = val_ff;  pos_in = pos_ff;
      term  = {32'b0, phi_ff, 32'b0} + {64'b0, plo_ff};
      rt    = {rem_ff[63:0], nn_ff[ACC_W-1:ACC_W-2]};
      trial = {root_ff, 2'b01};
      dt    = {dr_ff[62:0], num_ff[ACC_W-1]};
      ma    = mag32(rda_ff[DATA_W-1:0]);
      shamt = 8'd42 + {1'b0, k_ff};
      sh    = {128'b0, ma} << shamt;
      limit = neg_ff ? 33'h080000000 : 33'h07fffffff;
      over  = sat_ff || sticky_ff || (q_ff > limit);
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               n_in   = run.len;
               i_in   = '0;
               j_in   = '0;
               acc_in = '0;
               state_in = (run.bad || run.len == '0) ? ST_ERR : ST_T0;
            end
         end
         ST_T0: state_in = ST_T1;
         ST_T1: begin
            prod_in  = mag32(rda_ff[DATA_W-1:0]) * mag32(rdb_ff[DATA_W-1:0]);
            sign_in  = rda_ff[DATA_W-1] ^ rdb_ff[DATA_W-1];
            state_in = ST_T2;
         end
         ST_T2: begin
            plo_in   = prod_ff[31:0] * mag32(ovr_ff);
            sign_in  = sign_ff ^ ovr_ff[DATA_W-1];
            state_in = ST_T3;
         end
         ST_T3: begin
            phi_in   = prod_ff[63:32] * mag32(ovr_ff);
            state_in = ST_T4;
         end
         ST_T4: begin
            acc_in = sign_ff ? (acc_ff - term) : (acc_ff + term);
            state_in = ST_T0;
            if ((LEN_W'(j_ff) + 1'b1) == n_ff) begin
               j_in = '0;
               if ((LEN_W'(i_ff) + 1'b1) == n_ff) state_in = ST_CHK;
               else i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CHK: begin
            nn_in = acc_ff;
            k_in  = '0;
            state_in = (acc_ff[ACC_W-1] || acc_ff == '0) ? ST_ERR : ST_NORM;
         end
         ST_NORM: begin
            if (nn_ff[ACC_W-1:ACC_W-4] == 4'd0) begin
               nn_in = nn_ff << 2;
               k_in  = k_ff + 1'b1;
            end else begin
               rem_in  = '0;
               root_in = '0;
               cnt_in  = LEN_W'(63);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rt >= trial) begin
               rem_in  = rt - trial;
               root_in = {root_ff[62:0], 1'b1};
            end else begin
               rem_in  = rt;
               root_in = {root_ff[62:0], 1'b0};
            end
            nn_in  = nn_ff << 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               i_in = '0;
               state_in = ST_SCR;
            end
         end
         ST_SCR: state_in = ST_SCL;
         ST_SCL: begin
            num_in    = sh[ACC_W-1:0];
            sat_in    = |sh[159:ACC_W];
            neg_in    = rda_ff[DATA_W-1];
            dr_in     = '0;
            q_in      = '0;
            sticky_in = 1'b0;
            cnt_in    = LEN_W'(127);
            state_in  = ST_SCD;
         end
         ST_SCD: begin
            if (dt >= root_ff) begin
               dr_in = dt - root_ff;
               q_in  = {q_ff[31:0], 1'b1};
            end else begin
               dr_in = dt;
               q_in  = {q_ff[31:0], 1'b0};
            end
            sticky_in = sticky_ff | q_ff[32];
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SCO;
         end
         ST_SCO: begin
            vld_in = 1'b1;
            err_in = 1'b0;
            pos_in = i_ff;
            end_in = (LEN_W'(i_ff) + 1'b1) == n_ff;
            if (over) val_in = neg_ff ? 32'h80000000 : 32'h7fffffff;
            else      val_in = neg_ff ? (32'd0 - q_ff[31:0]) : q_ff[31:0];
            if (end_in) state_in = ST_IDLE;
            else begin
               i_in = i_ff + 1'b1;
               state_in = ST_SCR;
            end
         end
         ST_ERR: begin
            vld_in = 1'b1;
            err_in = 1'b1;
            end_in = 1'b1;
            val_in = '0;
            pos_in = '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;  cnt_ff <= cnt_in;  k_ff <= k_in;
      acc_ff <= acc_in;  nn_ff <= nn_in;  num_ff <= num_in;
      prod_ff <= prod_in;  plo_ff <= plo_in;  phi_ff <= phi_in;
      root_ff <= root_in;  dr_ff <= dr_in;  rem_ff <= rem_in;  q_ff <= q_in;
      sign_ff <= sign_in;  sticky_ff <= sticky_in;  sat_ff <= sat_in;
      neg_ff <= neg_in;  err_ff <= err_in;  end_ff <= end_in;
      val_ff <= val_in;  pos_ff <= pos_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_scaled_value = val_ff;
   assign rsp_position     = pos_ff;
   assign rsp_error        = err_ff;
   assign rsp_end_of_run   = end_ff;
endmodule

// ===== hdl/metric_vector_normalizer.sv =====
// Normalizes one sparse vector under an overlap matrix. Overlap writes and
// coefficient pushes are accepted while busy is low. The closing push
// starts a run that holds busy high: the quadratic form (one pass through
// states T0 to T4 per matrix term), a check and normalization of the sum,
// the square root, then the bit-serial divider for each coefficient, each
// result strobed for one cycle on rsp_valid.
// Busy drops in the cycle that shows the final result of the run.
// Results cannot be held off; take each one in the cycle it is shown.
module metric_vector_normalizer import mvn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [IDX_W-1:0]  req_row_index,
   input  logic [IDX_W-1:0]  req_col_index,
   input  logic [DATA_W-1:0] req_value,
   input  logic              req_last,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_scaled_value,
   output logic [IDX_W-1:0]  rsp_position,
   output logic              rsp_error,
   output logic              rsp_end_of_run
);
   wr_type  wr;
   run_type run_q, run_d;
   logic    push, pop, empty, active;

   assign busy = active || !empty;

   mvn_front u_front (
      .clock, .reset, .start, .busy, .req_func, .req_row_index,
      .req_col_index, .req_value, .req_last,
      .wr(wr), .push(push), .run(run_q)
   );

   mvn_queue u_queue (
      .clock, .reset, .push(push), .din(run_q), .pop(pop),
      .dout(run_d), .empty(empty)
   );

   mvn_back u_back (
      .clock, .reset, .wr(wr), .empty(empty), .run(run_d), .pop(pop),
      .active(active), .rsp_valid, .rsp_scaled_value, .rsp_position,
      .rsp_error, .rsp_end_of_run
   );
endmodule

// ===== hdl/mvn_checker.sv =====
`include "assert_macros.svh"

module mvn_checker import mvn_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_func,
   input logic [IDX_W-1:0]  req_row_index,
   input logic [IDX_W-1:0]  req_col_index,
   input logic [DATA_W-1:0] req_value,
   input logic              req_last,
   input logic              rsp_valid,
   input logic [DATA_W-1:0] rsp_scaled_value,
   input logic [IDX_W-1:0]  rsp_position,
   input logic              rsp_error,
   input logic              rsp_end_of_run
);
   logic push_close;
   assign push_close = start && !busy && (req_func == FUNC_PUSH) && req_last;

   `ASSERT_IMPLY(a_rsp_busy, clock, reset, rsp_valid && !rsp_end_of_run, busy)
   `ASSERT_IMPLY(a_err_form, clock, reset, rsp_valid && rsp_error,
                 rsp_end_of_run && rsp_scaled_value == '0 && rsp_position == '0)
   `ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid && !rsp_end_of_run, !rsp_valid)
   `ASSERT_NEXT(a_close_busy, clock, reset, push_close, busy)
   `ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)
endmodule

bind metric_vector_normalizer mvn_checker u_mvn_checker (.*);
